### sv/pufb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pufb_pkg
// Shared widths, register indexes, datapath op codes and the command/status
// structs between the controller and the datapath of the bipartite checker.
// ----------------------------------------------------------------------------
package pufb_pkg;

   // field widths
   localparam int NODE_W = 10;
   localparam int CFG_W  = 11;
   localparam int NUM_W  = 16;
   localparam int IDX_W  = 1;

   // parameter defaults
   localparam int MAX_NODES_DEF      = 1024;
   localparam int MAX_BASE_EDGES_DEF = 1024;

   // register indexes
   localparam logic [IDX_W-1:0] CSR_NODE_COUNT      = 1'd0;
   localparam logic [IDX_W-1:0] CSR_EDGES_PER_BATCH = 1'd1;

   // register reset values
   localparam logic [CFG_W-1:0] NODE_COUNT_RST = 11'd1024;
   localparam logic [CFG_W-1:0] EPB_RST        = 11'd1;

   // datapath ops
   localparam logic [3:0] OP_NONE   = 4'd0;
   localparam logic [3:0] OP_LATCH  = 4'd1;
   localparam logic [3:0] OP_STORE  = 4'd2;
   localparam logic [3:0] OP_FSTART = 4'd3;
   localparam logic [3:0] OP_FWALK  = 4'd4;
   localparam logic [3:0] OP_FCOMP  = 4'd5;
   localparam logic [3:0] OP_CHECK  = 4'd6;
   localparam logic [3:0] OP_SZ1    = 4'd7;
   localparam logic [3:0] OP_SZ2    = 4'd8;
   localparam logic [3:0] OP_LINK   = 4'd9;
   localparam logic [3:0] OP_BATCH  = 4'd10;
   localparam logic [3:0] OP_CLR    = 4'd11;
   localparam logic [3:0] OP_RPL_RD = 4'd12;
   localparam logic [3:0] OP_RPL_LD = 4'd13;

   // find operand select
   localparam logic [1:0] SEL_A  = 2'd0;
   localparam logic [1:0] SEL_B  = 2'd1;
   localparam logic [1:0] SEL_AN = 2'd2;
   localparam logic [1:0] SEL_BN = 2'd3;

   typedef struct packed {
      logic [3:0] op;
      logic [1:0] sel;
      logic       dst;     // 0: root to rx, 1: root to ry
   } cmd_type;

   typedef struct packed {
      logic in_range;
      logic mode;
      logic base_full;
      logic walk_root;
      logic start_is_root;
      logic comp_done;
      logic roots_equal;
      logic clr_last;
      logic rpl_done;
      logic batch_close;
      logic conflict;
   } sts_type;

endpackage

### sv/pufb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pufb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pufb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### sv/pufb_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pufb_dp
// Datapath: parent and set-size tables, base edge store, find/link registers,
// batch bookkeeping and configuration registers. Driven one op per cycle.
// ----------------------------------------------------------------------------
module pufb_dp #(
   parameter int MAX_NODES      = pufb_pkg::MAX_NODES_DEF,
   parameter int MAX_BASE_EDGES = pufb_pkg::MAX_BASE_EDGES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  pufb_pkg::cmd_type            cmd,
   output pufb_pkg::sts_type            sts,
   input  logic                         req_mode,
   input  logic [pufb_pkg::NODE_W-1:0]  req_node_a,
   input  logic [pufb_pkg::NODE_W-1:0]  req_node_b,
   input  logic                         csr_we,
   input  logic [pufb_pkg::IDX_W-1:0]   csr_index,
   input  logic [pufb_pkg::CFG_W-1:0]   csr_wdata,
   output logic                         rsp_valid,
   output logic [pufb_pkg::NUM_W-1:0]   rsp_batch_number
);

   import pufb_pkg::*;

   localparam int TBL = 2 * MAX_NODES;
   localparam int TW  = $clog2(TBL);
   localparam int SZW = TW + 1;
   localparam int BAW = (MAX_BASE_EDGES > 1) ? $clog2(MAX_BASE_EDGES) : 1;
   localparam int BCW = $clog2(MAX_BASE_EDGES + 1);
   localparam int EW  = 2 * NODE_W;
   localparam logic [CFG_W-1:0] NCAP =
      (MAX_NODES >= (1 << CFG_W)) ? {CFG_W{1'b1}} : CFG_W'(MAX_NODES);

   // control registers
   logic [CFG_W-1:0] node_count_ff, node_count_in;
   logic [CFG_W-1:0] epb_ff, epb_in;
   logic [BCW-1:0]   bcount_ff, bcount_in;
   logic [BCW-1:0]   rpl_ff, rpl_in;
   logic [TW-1:0]    clr_ff, clr_in;
   logic [NUM_W-1:0] batch_ff, batch_in;
   logic [CFG_W-1:0] inb_ff, inb_in;
   logic             conf_ff, conf_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [NODE_W-1:0] a_ff, a_in, b_ff, b_in;
   logic [CFG_W-1:0]  n_ff, n_in;
   logic              mode_ff, mode_in;
   logic [TW-1:0]     cur_ff, cur_in, start_ff, start_in, root_ff, root_in;
   logic [TW-1:0]     rx_ff, rx_in, ry_ff, ry_in;
   logic [SZW-1:0]    szx_ff, szx_in;
   logic [NUM_W-1:0]  rsp_num_ff, rsp_num_in;

   // memory ports
   logic           p_we, s_we, e_we;
   logic [TW-1:0]  p_waddr, p_raddr, s_waddr, s_raddr;
   logic [TW-1:0]  p_wdata, p_rdata;
   logic [SZW-1:0] s_wdata, s_rdata;
   logic [BAW-1:0] e_waddr, e_raddr;
   logic [EW-1:0]  e_wdata, e_rdata;

   logic [CFG_W-1:0] n_eff, limit, inb_next;
   logic [TW-1:0]    x_sel, small_idx, big_idx;

   pufb_ram #(.WIDTH(TW), .DEPTH(TBL)) u_parent (
      .clock(clock), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
      .raddr(p_raddr), .rdata(p_rdata));

   pufb_ram #(.WIDTH(SZW), .DEPTH(TBL)) u_size (
      .clock(clock), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
      .raddr(s_raddr), .rdata(s_rdata));

   pufb_ram #(.WIDTH(EW), .DEPTH(MAX_BASE_EDGES)) u_store (
      .clock(clock), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
      .raddr(e_raddr), .rdata(e_rdata));

   // status
   assign n_eff    = (node_count_ff > NCAP) ? NCAP : node_count_ff;
   assign limit    = (epb_ff == '0) ? CFG_W'(1) : epb_ff;
   assign inb_next = inb_ff + CFG_W'(1);

   always_comb begin
      sts.in_range      = ({1'b0, a_ff} < n_ff) && ({1'b0, b_ff} < n_ff);
      sts.mode          = mode_ff;
      sts.base_full     = (bcount_ff == BCW'(MAX_BASE_EDGES));
      sts.walk_root     = (p_rdata == cur_ff);
      sts.start_is_root = (start_ff == cur_ff);
      sts.comp_done     = (p_rdata == root_ff);
      sts.roots_equal   = (rx_ff == ry_ff);
      sts.clr_last      = (clr_ff == TW'(TBL - 1));
      sts.rpl_done      = (rpl_ff == bcount_ff);
      sts.batch_close   = (inb_next >= limit);
      sts.conflict      = conf_ff;
   end

   // find operand
   always_comb begin
      case (cmd.sel)
         SEL_A:   x_sel = TW'(a_ff);
         SEL_B:   x_sel = TW'(b_ff);
         SEL_AN:  x_sel = TW'(a_ff) + TW'(n_ff);
         default: x_sel = TW'(b_ff) + TW'(n_ff);
      endcase
   end

   // union by size: smaller root goes under larger, ties under the second
   always_comb begin
      if (szx_ff > s_rdata) begin
         small_idx = ry_ff;
         big_idx   = rx_ff;
      end else begin
         small_idx = rx_ff;
         big_idx   = ry_ff;
      end
   end

   // op decode
   always_comb begin
      node_count_in = node_count_ff;
      epb_in        = epb_ff;
      bcount_in     = bcount_ff;
      rpl_in        = rpl_ff;
      clr_in        = clr_ff;
      batch_in      = batch_ff;
      inb_in        = inb_ff;
      conf_in       = conf_ff;
      rsp_valid_in  = 1'b0;
      a_in          = a_ff;
      b_in          = b_ff;
      n_in          = n_ff;
      mode_in       = mode_ff;
      cur_in        = cur_ff;
      start_in      = start_ff;
      root_in       = root_ff;
      rx_in         = rx_ff;
      ry_in         = ry_ff;
      szx_in        = szx_ff;
      rsp_num_in    = rsp_num_ff;
      p_we          = 1'b0;
      p_waddr       = cur_ff;
      p_wdata       = root_ff;
      p_raddr       = cur_ff;
      s_we          = 1'b0;
      s_waddr       = big_idx;
      s_wdata       = szx_ff + s_rdata;
      s_raddr       = rx_ff;
      e_we          = 1'b0;
      e_waddr       = bcount_ff[BAW-1:0];
      e_wdata       = {a_ff, b_ff};
      e_raddr       = rpl_ff[BAW-1:0];

      if (csr_we) begin
         unique case (csr_index)
            CSR_NODE_COUNT:      node_count_in = csr_wdata;
            CSR_EDGES_PER_BATCH: epb_in        = csr_wdata;
            default: ;
         endcase
      end

      unique case (cmd.op)
         OP_LATCH: begin
            a_in    = req_node_a;
            b_in    = req_node_b;
            mode_in = req_mode;
            n_in    = n_eff;
         end
         OP_STORE: begin
            e_we      = 1'b1;
            bcount_in = bcount_ff + BCW'(1);
         end
         OP_FSTART: begin
            p_raddr  = x_sel;
            cur_in   = x_sel;
            start_in = x_sel;
         end
         OP_FWALK: begin
            if (sts.walk_root) begin
               root_in = cur_ff;
               if (cmd.dst) begin
                  ry_in = cur_ff;
               end else begin
                  rx_in = cur_ff;
               end
               // restart at the first node for path compression
               p_raddr = start_ff;
               cur_in  = start_ff;
            end else begin
               p_raddr = p_rdata;
               cur_in  = p_rdata;
            end
         end
         OP_FCOMP: begin
            p_we    = 1'b1;
            p_raddr = p_rdata;
            cur_in  = p_rdata;
         end
         OP_CHECK: begin
            if (sts.roots_equal) begin
               conf_in = 1'b1;
            end
         end
         OP_SZ1: begin
            s_raddr = rx_ff;
         end
         OP_SZ2: begin
            s_raddr = ry_ff;
            szx_in  = s_rdata;
         end
         OP_LINK: begin
            p_we    = 1'b1;
            p_waddr = small_idx;
            p_wdata = big_idx;
            s_we    = 1'b1;
         end
         OP_BATCH: begin
            if (sts.batch_close) begin
               rsp_valid_in = conf_ff;
               rsp_num_in   = batch_ff;
               batch_in     = batch_ff + NUM_W'(1);
               inb_in       = '0;
               conf_in      = 1'b0;
            end else begin
               inb_in = inb_next;
            end
         end
         OP_CLR: begin
            p_we    = 1'b1;
            p_waddr = clr_ff;
            p_wdata = clr_ff;
            s_we    = 1'b1;
            s_waddr = clr_ff;
            s_wdata = SZW'(1);
            clr_in  = sts.clr_last ? '0 : clr_ff + TW'(1);
            rpl_in  = '0;
         end
         OP_RPL_RD: begin
            rpl_in = rpl_ff + BCW'(1);
         end
         OP_RPL_LD: begin
            a_in = e_rdata[EW-1:NODE_W];
            b_in = e_rdata[NODE_W-1:0];
         end
         default: ;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NODE_COUNT_RST;
         epb_ff        <= EPB_RST;
         bcount_ff     <= '0;
         rpl_ff        <= '0;
         clr_ff        <= '0;
         batch_ff      <= NUM_W'(1);
         inb_ff        <= '0;
         conf_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         node_count_ff <= node_count_in;
         epb_ff        <= epb_in;
         bcount_ff     <= bcount_in;
         rpl_ff        <= rpl_in;
         clr_ff        <= clr_in;
         batch_ff      <= batch_in;
         inb_ff        <= inb_in;
         conf_ff       <= conf_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      a_ff       <= a_in;
      b_ff       <= b_in;
      n_ff       <= n_in;
      mode_ff    <= mode_in;
      cur_ff     <= cur_in;
      start_ff   <= start_in;
      root_ff    <= root_in;
      rx_ff      <= rx_in;
      ry_ff      <= ry_in;
      szx_ff     <= szx_in;
      rsp_num_ff <= rsp_num_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_batch_number = rsp_num_ff;

endmodule

### sv/pufb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pufb_ctrl
// Controller: sequences finds, links, batch close, table clear and replay of
// the stored base edges, issuing one datapath op per cycle.
// ----------------------------------------------------------------------------
module pufb_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  pufb_pkg::sts_type sts,
   output pufb_pkg::cmd_type cmd
);

   import pufb_pkg::*;

   localparam logic [3:0] S_CLR     = 4'd0;
   localparam logic [3:0] S_IDLE    = 4'd1;
   localparam logic [3:0] S_DECIDE  = 4'd2;
   localparam logic [3:0] S_FSTART  = 4'd3;
   localparam logic [3:0] S_FWALK   = 4'd4;
   localparam logic [3:0] S_FCOMP   = 4'd5;
   localparam logic [3:0] S_FEND    = 4'd6;
   localparam logic [3:0] S_SZ1     = 4'd7;
   localparam logic [3:0] S_SZ2     = 4'd8;
   localparam logic [3:0] S_LINK    = 4'd9;
   localparam logic [3:0] S_BATCH   = 4'd10;
   localparam logic [3:0] S_RPL_RD  = 4'd11;
   localparam logic [3:0] S_RPL_LD  = 4'd12;
   localparam logic [3:0] S_RPL_CHK = 4'd13;

   // phase: conflict check, first merge, second merge
   localparam logic [1:0] PH_CHK = 2'd0;
   localparam logic [1:0] PH_M1  = 2'd1;
   localparam logic [1:0] PH_M2  = 2'd2;

   logic [3:0] state_ff, state_in;
   logic [1:0] ph_ff, ph_in;
   logic       sub_ff, sub_in;
   logic       replay_ff, replay_in;
   logic [3:0] mdone_state;
   logic [1:0] mdone_ph;

   // where to go once a merge is finished
   always_comb begin
      mdone_ph = ph_ff;
      if (ph_ff == PH_M1) begin
         mdone_state = S_FSTART;
         mdone_ph    = PH_M2;
      end else if (replay_ff) begin
         mdone_state = S_RPL_RD;
      end else if (sts.mode) begin
         mdone_state = S_BATCH;
      end else begin
         mdone_state = S_IDLE;
      end
   end

   // find operand for this phase and operand slot
   always_comb begin
      case ({ph_ff, sub_ff})
         {PH_CHK, 1'b0}: cmd.sel = SEL_A;
         {PH_CHK, 1'b1}: cmd.sel = SEL_B;
         {PH_M1,  1'b0}: cmd.sel = SEL_A;
         {PH_M1,  1'b1}: cmd.sel = SEL_BN;
         {PH_M2,  1'b0}: cmd.sel = SEL_AN;
         default:        cmd.sel = SEL_B;
      endcase
      cmd.dst = sub_ff;
   end

   // next state
   always_comb begin
      state_in  = state_ff;
      ph_in     = ph_ff;
      sub_in    = sub_ff;
      replay_in = replay_ff;
      cmd.op    = OP_NONE;
      unique case (state_ff)
         S_CLR: begin
            cmd.op = OP_CLR;
            if (sts.clr_last) begin
               state_in = replay_ff ? S_RPL_RD : S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.op   = OP_LATCH;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            sub_in = 1'b0;
            if (!sts.in_range) begin
               state_in = S_IDLE;
            end else if (!sts.mode) begin
               if (sts.base_full) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.op   = OP_STORE;
                  ph_in    = PH_M1;
                  state_in = S_FSTART;
               end
            end else begin
               ph_in    = PH_CHK;
               state_in = S_FSTART;
            end
         end
         S_FSTART: begin
            cmd.op   = OP_FSTART;
            state_in = S_FWALK;
         end
         S_FWALK: begin
            cmd.op = OP_FWALK;
            if (sts.walk_root) begin
               state_in = sts.start_is_root ? S_FEND : S_FCOMP;
            end
         end
         S_FCOMP: begin
            cmd.op = OP_FCOMP;
            if (sts.comp_done) begin
               state_in = S_FEND;
            end
         end
         S_FEND: begin
            if (!sub_ff) begin
               sub_in   = 1'b1;
               state_in = S_FSTART;
            end else begin
               sub_in = 1'b0;
               if (ph_ff == PH_CHK) begin
                  cmd.op   = OP_CHECK;
                  ph_in    = PH_M1;
                  state_in = S_FSTART;
               end else if (sts.roots_equal) begin
                  ph_in    = mdone_ph;
                  state_in = mdone_state;
               end else begin
                  state_in = S_SZ1;
               end
            end
         end
         S_SZ1: begin
            cmd.op   = OP_SZ1;
            state_in = S_SZ2;
         end
         S_SZ2: begin
            cmd.op   = OP_SZ2;
            state_in = S_LINK;
         end
         S_LINK: begin
            cmd.op   = OP_LINK;
            ph_in    = mdone_ph;
            state_in = mdone_state;
         end
         S_BATCH: begin
            cmd.op = OP_BATCH;
            if (sts.batch_close && sts.conflict) begin
               replay_in = 1'b1;
               state_in  = S_CLR;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_RPL_RD: begin
            if (sts.rpl_done) begin
               replay_in = 1'b0;
               state_in  = S_IDLE;
            end else begin
               cmd.op   = OP_RPL_RD;
               state_in = S_RPL_LD;
            end
         end
         S_RPL_LD: begin
            cmd.op   = OP_RPL_LD;
            state_in = S_RPL_CHK;
         end
         S_RPL_CHK: begin
            sub_in = 1'b0;
            if (sts.in_range) begin
               ph_in    = PH_M1;
               state_in = S_FSTART;
            end else begin
               state_in = S_RPL_RD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLR;
         ph_ff     <= PH_CHK;
         sub_ff    <= 1'b0;
         replay_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         ph_ff     <= ph_in;
         sub_ff    <= sub_in;
         replay_ff <= replay_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   // checks
   a_reset_clears: assert property (@(posedge clock)
      reset |=> (state_ff == S_CLR) && !replay_ff)
      else $error("reset did not start the table clear");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted beat did not raise busy");

   a_rebuild: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BATCH && sts.batch_close && sts.conflict)
      |=> (state_ff == S_CLR) && replay_ff)
      else $error("conflicting batch did not start a rebuild");

   a_replay_busy: assert property (@(posedge clock) disable iff (reset)
      replay_ff |-> (state_ff != S_IDLE) && (ph_ff != PH_CHK || state_ff == S_CLR
         || state_ff == S_RPL_RD || state_ff == S_RPL_LD || state_ff == S_RPL_CHK))
      else $error("replay ran a conflict check or went idle");

endmodule

### sv/parity_union_find_bipartite_check_core.sv
`timescale 1ns / 1ps
// An in-range base edge with room in the store is stored, then runs two merges;
//   an in-range test edge runs a conflict check, two merges and the batch step.
// A merge of one set skips the size reads and link. A verdict is registered in
//   the batch step and is out the cycle after it; a conflicting batch then clears
//   the table, then replays each stored base edge, merged if in range.
// One beat per busy period; no result stall; reset clears all 2*MAX_NODES entries.
// ----------------------------------------------------------------------------
// parity_union_find_bipartite_check_core
// Incremental two-colorability checker on a doubled-node disjoint-set table;
// reports the number of each batch of test edges that hit a conflict.
// ----------------------------------------------------------------------------
module parity_union_find_bipartite_check_core #(
   parameter int MAX_NODES      = pufb_pkg::MAX_NODES_DEF,
   parameter int MAX_BASE_EDGES = pufb_pkg::MAX_BASE_EDGES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_mode,
   input  logic [pufb_pkg::NODE_W-1:0] req_node_a,
   input  logic [pufb_pkg::NODE_W-1:0] req_node_b,
   output logic                        rsp_valid,
   output logic [pufb_pkg::NUM_W-1:0]  rsp_batch_number,
   input  logic                        csr_we,
   input  logic [pufb_pkg::IDX_W-1:0]  csr_index,
   input  logic [pufb_pkg::CFG_W-1:0]  csr_wdata
);

   import pufb_pkg::*;

   cmd_type cmd;
   sts_type sts;

   pufb_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   pufb_dp #(
      .MAX_NODES      (MAX_NODES),
      .MAX_BASE_EDGES (MAX_BASE_EDGES)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_mode         (req_mode),
      .req_node_a       (req_node_a),
      .req_node_b       (req_node_b),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_valid        (rsp_valid),
      .rsp_batch_number (rsp_batch_number)
   );

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for parity_union_find_bipartite_check_core. A directed
// table covers the range edges, register extremes and batch corner cases,
// then random edge traffic under several sender gap rates is scored against
// a behavioral doubled-node disjoint-set model kept inside the bench. The
// run closes by filling the base edge store past its capacity.
// ----------------------------------------------------------------------------
module tb;
   import pufb_pkg::*;

   localparam int NMAX      = MAX_NODES_DEF;
   localparam int EMAX      = MAX_BASE_EDGES_DEF;
   localparam int TBL       = 2 * NMAX;
   localparam int CYC_LIMIT = 20000000;

   localparam logic MODE_BASE = 1'b0;
   localparam logic MODE_TEST = 1'b1;

   typedef enum logic {ROW_EDGE, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type     kind;
      logic             mode;
      logic [NODE_W-1:0] a;
      logic [NODE_W-1:0] b;
      logic [IDX_W-1:0] idx;
      logic [CFG_W-1:0] data;
      bit               typed;
      logic [NUM_W-1:0] num;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_mode = 1'b0;
   logic [NODE_W-1:0] req_node_a = '0;
   logic [NODE_W-1:0] req_node_b = '0;
   logic rsp_valid;
   logic [NUM_W-1:0] rsp_batch_number;
   logic csr_we = 1'b0;
   logic [IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0] csr_wdata = '0;

   int errors = 0;
   int cycles = 0;
   int gap_pct = 0;

   // expected conflicting batch numbers, oldest first
   logic [NUM_W-1:0] conflict_batches[$];

   // bipartite model state
   logic [10:0] parent[TBL];
   logic [11:0] set_size[TBL];
   logic [NODE_W-1:0] base_a[EMAX];
   logic [NODE_W-1:0] base_b[EMAX];
   int base_count;
   logic [NUM_W-1:0] batch_no;
   int in_batch;
   bit saw_conflict;
   logic [CFG_W-1:0] cfg_nodes;
   logic [CFG_W-1:0] cfg_epb;

   always #5 clock = ~clock;

   parity_union_find_bipartite_check_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_mode(req_mode), .req_node_a(req_node_a), .req_node_b(req_node_b),
      .rsp_valid(rsp_valid), .rsp_batch_number(rsp_batch_number),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   task automatic report(input string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
   endtask

   function automatic int eff_nodes();
      return (cfg_nodes > NMAX) ? NMAX : int'(cfg_nodes);
   endfunction

   function automatic int root_of(input int v);
      int r;
      int nx;
      r = v;
      while (int'(parent[r]) != r) r = int'(parent[r]);
      // path compression
      while (v != r) begin
         nx = int'(parent[v]);
         parent[v] = 11'(r);
         v = nx;
      end
      return r;
   endfunction

   function automatic void join_sets(input int x, input int y);
      int rx;
      int ry;
      int t;
      rx = root_of(x);
      ry = root_of(y);
      if (rx == ry) return;
      if (set_size[rx] > set_size[ry]) begin
         t = rx; rx = ry; ry = t;
      end
      parent[rx] = 11'(ry);
      set_size[ry] = set_size[ry] + set_size[rx];
   endfunction

   function automatic void link_edge(input int a, input int b, input int n);
      join_sets(a, b + n);
      join_sets(a + n, b);
   endfunction

   function automatic void clear_sets();
      for (int i = 0; i < TBL; i++) begin
         parent[i] = 11'(i);
         set_size[i] = 12'd1;
      end
   endfunction

   // model of one accepted edge; returns 1 with the batch number on a verdict
   function automatic bit model_edge(input logic m, input int a, input int b,
                                     output logic [NUM_W-1:0] num);
      int n;
      int lim;
      bit hit;
      n = eff_nodes();
      hit = 0;
      num = '0;
      if (a >= n || b >= n) return 0;
      if (m == MODE_BASE) begin
         if (base_count >= EMAX) return 0;
         base_a[base_count] = NODE_W'(a);
         base_b[base_count] = NODE_W'(b);
         base_count++;
         link_edge(a, b, n);
         return 0;
      end
      if (root_of(a) == root_of(b)) saw_conflict = 1;
      link_edge(a, b, n);
      in_batch++;
      lim = (cfg_epb == 0) ? 1 : int'(cfg_epb);
      if (in_batch < lim) return 0;
      if (saw_conflict) begin
         hit = 1;
         num = batch_no;
         // rebuild from the stored base edges
         clear_sets();
         for (int i = 0; i < base_count; i++)
            if (base_a[i] < n && base_b[i] < n)
               link_edge(int'(base_a[i]), int'(base_b[i]), n);
      end
      batch_no = batch_no + 1'b1;
      in_batch = 0;
      saw_conflict = 0;
      return hit;
   endfunction

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (conflict_batches.size() == 0)
            report($sformatf("unexpected batch number %0d", rsp_batch_number));
         else begin
            if (rsp_batch_number !== conflict_batches[0])
               report($sformatf("batch_number got %0d want %0d",
                                rsp_batch_number, conflict_batches[0]));
            void'(conflict_batches.pop_front());
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYC_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("tb NOT OK");
         $finish;
      end
   end

   // one edge beat; called and returns at a falling edge
   task automatic send_edge(input logic m, input logic [NODE_W-1:0] a,
                            input logic [NODE_W-1:0] b, input bit typed,
                            input logic [NUM_W-1:0] typed_num);
      logic [NUM_W-1:0] num;
      bit hit;
      while ($urandom_range(99, 0) < gap_pct) @(negedge clock);
      while (busy) @(negedge clock);
      start = 1'b1;
      req_mode = m;
      req_node_a = a;
      req_node_b = b;
      hit = model_edge(m, int'(a), int'(b), num);
      if (typed) conflict_batches = {conflict_batches, typed_num};
      else if (hit) conflict_batches = {conflict_batches, num};
      @(negedge clock);
      start = 1'b0;
   endtask

   // register write with the block drained and quiet
   task automatic write_csr(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
      while (conflict_batches.size() != 0 || busy) @(negedge clock);
      repeat (60) @(negedge clock);
      while (busy) @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      if (idx == CSR_NODE_COUNT) cfg_nodes = val;
      else cfg_epb = val;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   function automatic stim_row_type edge_row(input logic m, input int a, input int b);
      stim_row_type r;
      r = '{ROW_EDGE, m, NODE_W'(a), NODE_W'(b), '0, '0, 0, '0};
      return r;
   endfunction

   function automatic stim_row_type csr_row(input logic [IDX_W-1:0] idx, input int v);
      stim_row_type r;
      r = '{ROW_CSR, MODE_BASE, '0, '0, idx, CFG_W'(v), 0, '0};
      return r;
   endfunction

   stim_row_type directed[$];

   initial begin
      int n;
      int a;
      int b;
      logic m;
      stim_row_type r;

      clear_sets();
      base_count = 0;
      batch_no = NUM_W'(1);
      in_batch = 0;
      saw_conflict = 0;
      cfg_nodes = NODE_COUNT_RST;
      cfg_epb = EPB_RST;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table
      r = edge_row(MODE_TEST, 0, 0); r.typed = 1; r.num = NUM_W'(1);
      directed = {directed, r};                                   // self loop after reset
      directed = {directed, edge_row(MODE_TEST, 1023, 1022)};     // top ids, clean batch
      directed = {directed, edge_row(MODE_BASE, 0, 1)};
      directed = {directed, edge_row(MODE_BASE, 1, 2)};
      directed = {directed, edge_row(MODE_BASE, 2, 0)};           // odd base cycle
      directed = {directed, edge_row(MODE_TEST, 0, 1)};
      directed = {directed, csr_row(CSR_NODE_COUNT, 2047)};       // clamps to max
      directed = {directed, edge_row(MODE_TEST, 1023, 512)};
      directed = {directed, csr_row(CSR_NODE_COUNT, 0)};          // everything ignored
      directed = {directed, edge_row(MODE_TEST, 0, 0)};
      directed = {directed, edge_row(MODE_BASE, 0, 0)};
      directed = {directed, csr_row(CSR_NODE_COUNT, 1)};
      directed = {directed, edge_row(MODE_TEST, 0, 0)};
      directed = {directed, csr_row(CSR_NODE_COUNT, 5)};
      directed = {directed, edge_row(MODE_TEST, 7, 1)};           // out of range
      directed = {directed, edge_row(MODE_TEST, 1, 5)};           // out of range
      directed = {directed, csr_row(CSR_EDGES_PER_BATCH, 0)};     // acts as one
      directed = {directed, edge_row(MODE_TEST, 3, 4)};
      directed = {directed, csr_row(CSR_EDGES_PER_BATCH, 3)};
      directed = {directed, edge_row(MODE_TEST, 3, 4)};
      directed = {directed, edge_row(MODE_TEST, 4, 3)};
      directed = {directed, csr_row(CSR_EDGES_PER_BATCH, 1)};     // lowered mid batch
      directed = {directed, edge_row(MODE_TEST, 2, 2)};
      directed = {directed, csr_row(CSR_EDGES_PER_BATCH, 1024)};
      directed = {directed, edge_row(MODE_TEST, 4, 4)};

      foreach (directed[i]) begin
         if (directed[i].kind == ROW_CSR) write_csr(directed[i].idx, directed[i].data);
         else send_edge(directed[i].mode, directed[i].a, directed[i].b,
                        directed[i].typed, directed[i].num);
      end

      // random part: gap phases, each split into config windows
      for (int ph = 0; ph < 3; ph++) begin
         gap_pct = (ph == 0) ? 0 : (ph == 1) ? 87 : 12;
         for (int w = 0; w < 6; w++) begin
            case ($urandom_range(5, 0))
               0: write_csr(CSR_NODE_COUNT, CFG_W'(1024));
               1: write_csr(CSR_NODE_COUNT, CFG_W'($urandom_range(2047, 1025)));
               2: write_csr(CSR_NODE_COUNT, CFG_W'($urandom_range(3, 1)));
               default: write_csr(CSR_NODE_COUNT, CFG_W'($urandom_range(48, 4)));
            endcase
            case ($urandom_range(5, 0))
               0: write_csr(CSR_EDGES_PER_BATCH, CFG_W'($urandom_range(1, 0)));
               1: write_csr(CSR_EDGES_PER_BATCH, CFG_W'($urandom_range(2047, 1024)));
               default: write_csr(CSR_EDGES_PER_BATCH, CFG_W'($urandom_range(16, 3)));
            endcase
            for (int k = 0; k < 20; k++) begin
               n = eff_nodes();
               m = ($urandom_range(99, 0) < 8) ? MODE_BASE : MODE_TEST;
               if (n == 0 || $urandom_range(99, 0) < 10) begin
                  a = int'($urandom_range(1023, 0));
                  b = int'($urandom_range(1023, 0));
               end else begin
                  a = int'($urandom_range(n - 1, 0));
                  b = int'($urandom_range(n - 1, 0));
               end
               send_edge(m, NODE_W'(a), NODE_W'(b), 0, '0);
            end
         end
      end

      // fill the base store past capacity, then a few verdicts
      gap_pct = 0;
      write_csr(CSR_NODE_COUNT, CFG_W'(1024));
      write_csr(CSR_EDGES_PER_BATCH, CFG_W'(2));
      while (base_count < EMAX)
         send_edge(MODE_BASE, NODE_W'($urandom_range(1023, 0)),
                   NODE_W'($urandom_range(1023, 0)), 0, '0);
      for (int k = 0; k < 6; k++)
         send_edge(MODE_BASE, NODE_W'($urandom_range(1023, 0)),
                   NODE_W'($urandom_range(1023, 0)), 0, '0);
      for (int k = 0; k < 10; k++)
         send_edge(MODE_TEST, NODE_W'($urandom_range(1023, 0)),
                   NODE_W'($urandom_range(1023, 0)), 0, '0);

      // drain
      while (conflict_batches.size() != 0 || busy) @(negedge clock);
      repeat (200) @(negedge clock);
      if (errors == 0 && conflict_batches.size() == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule

### files.f
sv/pufb_pkg.sv
sv/pufb_ram.sv
sv/pufb_dp.sv
sv/pufb_ctrl.sv
sv/parity_union_find_bipartite_check_core.sv
bench/tb.sv
